[src/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants and codes for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // tab stops every 8 columns
  localparam int TAB_SHIFT = 3;
  localparam int TAB_STOP  = 1 << TAB_SHIFT;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  // work class handed from the front to the back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_CLEAR,
    OP_READ
  } op_e;

endpackage

[src/tcce_queue.sv]
// ----------------------------------------------------------------------------
// tcce_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module tcce_queue #(
  parameter type entry_t = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_data_o
);
  import tcce_pkg::*;

  entry_t     slots_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/tcce_front.sv]
// ----------------------------------------------------------------------------
// tcce_front
// Accepts requests, tracks the cursor and classifies each request into
// the memory work the back has to do.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int  COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int  ROWS    = tcce_pkg::DEF_ROWS,
  parameter type entry_t = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         init_done_i,
  input  logic                         cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tcce_pkg::FUNC_W-1:0]  func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcce_pkg::INDEX_W-1:0] cell_index_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output entry_t                       push_data_o
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW1   = CW + 1;
  localparam int RW1   = RW + 1;
  localparam int MW    = (AW > INDEX_W) ? AW : INDEX_W;

  logic [ATTR_W-1:0] attr_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW1-1:0]    col_n;
  logic [CW1-1:0]    tab_sum;
  logic [RW1-1:0]    row_n;
  logic              row_inc;
  logic              scroll;
  op_e               op;
  logic [AW-1:0]     put_addr;
  logic [AW-1:0]     lin_new;
  logic              accept;

  assign in_ready_o   = init_done_i && push_ready_i;
  assign push_valid_o = in_valid_i && init_done_i;
  assign accept       = in_valid_i && in_ready_o;

  assign tab_sum  = CW1'(col_q) + CW1'(TAB_STOP);
  assign put_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

  always_comb begin
    col_n   = CW1'(col_q);
    row_inc = 1'b0;
    row_n   = RW1'(row_q);
    scroll  = 1'b0;
    op      = OP_NONE;
    case (func_i)
      FUNC_PUT: begin
        if (char_code_i == CH_BS) begin
          col_n = (col_q == '0) ? '0 : CW1'(col_q) - CW1'(1);
        end else if (char_code_i == CH_TAB) begin
          col_n = {tab_sum[CW:TAB_SHIFT], {TAB_SHIFT{1'b0}}};
        end else if (char_code_i == CH_CR) begin
          col_n = '0;
        end else if (char_code_i == CH_LF) begin
          col_n   = '0;
          row_inc = 1'b1;
        end else if (char_code_i >= CH_SPACE) begin
          op    = OP_WRITE;
          col_n = CW1'(col_q) + CW1'(1);
        end
        // wrap off the right edge
        if (col_n >= CW1'(COLUMNS)) begin
          col_n   = '0;
          row_inc = 1'b1;
        end
        row_n = RW1'(row_q) + RW1'(row_inc);
        // off the bottom: scroll and stay on the last row
        if (row_n >= RW1'(ROWS)) begin
          scroll = 1'b1;
          row_n  = RW1'(ROWS - 1);
        end
      end
      FUNC_CLEAR: begin
        op    = OP_CLEAR;
        col_n = '0;
        row_n = '0;
      end
      FUNC_READ: begin
        op = OP_READ;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  assign col_d   = CW'(col_n);
  assign row_d   = RW'(row_n);
  assign lin_new = AW'(row_d) * AW'(COLUMNS) + AW'(col_d);

  always_comb begin
    push_data_o           = '0;
    push_data_o.op        = op;
    push_data_o.scroll    = scroll;
    push_data_o.addr      = (op == OP_READ) ? AW'(cell_index_i) : put_addr;
    push_data_o.glyph     = char_code_i;
    push_data_o.attr      = attr_q;
    push_data_o.read_ok   = MW'(cell_index_i) < MW'(CELLS);
    push_data_o.cur_index = INDEX_W'(lin_new);
    push_data_o.cur_col   = COL_W'(col_d);
    push_data_o.cur_row   = ROW_W'(row_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

[src/tcce_back.sv]
// ----------------------------------------------------------------------------
// tcce_back
// Owns the screen memory: cell writes and reads, scroll copy, blanking,
// the clearing pass after reset, and the result register.
// ----------------------------------------------------------------------------
module tcce_back #(
  parameter int  COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int  ROWS    = tcce_pkg::DEF_ROWS,
  parameter type entry_t = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  output logic                         init_done_o,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  entry_t                       pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tcce_pkg::INDEX_W-1:0] cursor_index_o,
  output logic [tcce_pkg::COL_W-1:0]   cursor_col_o,
  output logic [tcce_pkg::ROW_W-1:0]   cursor_row_o,
  output logic                         scrolled_o,
  output logic [tcce_pkg::CELL_W-1:0]  read_cell_o
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_BLANK  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     wptr_q, wptr_d;
  logic              copy_v_q, copy_v_d;
  entry_t            cmd_q, cmd_d;
  logic [CELL_W-1:0] cells_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic              slot_free;
  logic              pop;
  logic              res_load;
  entry_t            res_cmd;
  logic [CELL_W-1:0] res_cell;
  logic              res_valid_q;

  assign init_done_o = (state_q != ST_INIT);
  assign slot_free   = !res_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == ST_IDLE) && slot_free;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    wptr_d    = ptr_q;
    copy_v_d  = 1'b0;
    cmd_d     = cmd_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = {cmd_q.attr, CH_SPACE};
    mem_re    = 1'b0;
    mem_raddr = ptr_q + AW'(COLUMNS);
    res_load  = 1'b0;
    res_cmd   = cmd_q;
    res_cell  = '0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BLANK;
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (pop) begin
          cmd_d   = pop_data_i;
          ptr_d   = '0;
          res_cmd = pop_data_i;
          case (pop_data_i.op)
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = pop_data_i.addr;
              mem_wdata = {pop_data_i.attr, pop_data_i.glyph};
              if (pop_data_i.scroll) begin
                state_d = ST_SCROLL;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_CLEAR: begin
              state_d = ST_BLANK;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = pop_data_i.addr;
              state_d   = ST_READ;
            end
            default: begin
              if (pop_data_i.scroll) begin
                state_d = ST_SCROLL;
              end else begin
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read last cycle
        if (copy_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = wptr_q;
          mem_wdata = rdata_q;
        end
        if (ptr_q == COPY_END) begin
          state_d = ST_BLANK;
        end else begin
          mem_re   = 1'b1;
          copy_v_d = 1'b1;
          wptr_d   = ptr_q;
          ptr_d    = ptr_q + AW'(1);
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (ptr_q == LAST_CELL) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_cell = cmd_q.read_ok ? rdata_q : '0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      copy_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      copy_v_q <= copy_v_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= wptr_d;
    cmd_q  <= cmd_d;
    if (res_load) begin
      cursor_index_o <= res_cmd.cur_index;
      cursor_col_o   <= res_cmd.cur_col;
      cursor_row_o   <= res_cmd.cur_row;
      scrolled_o     <= res_cmd.scroll;
      read_cell_o    <= res_cell;
    end
  end

  // screen memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cells_q[mem_raddr];
    end
  end

  assign out_valid_o = res_valid_q;

endmodule

[src/text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// COLUMNS x ROWS text screen with cursor, control-character handling and
// scrolling; every request returns the linear cursor index.
// ----------------------------------------------------------------------------
// After reset the block blanks all COLUMNS*ROWS cells (2000 by default) of
// the screen memory and takes no request until that pass ends; attribute
// writes are taken throughout. The front takes one request per cycle into a
// two-entry queue while it has room; the back, bound by the single-write-port
// screen memory, takes one request at a time: stores a character, moves the
// cursor, reads a cell, or clears or scrolls the screen cell by cell. Results
// come out in request order through a one-entry output register.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcce_pkg::ATTR_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tcce_pkg::FUNC_W-1:0]  func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcce_pkg::INDEX_W-1:0] cell_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tcce_pkg::INDEX_W-1:0] cursor_index_o,
  output logic [tcce_pkg::COL_W-1:0]   cursor_col_o,
  output logic [tcce_pkg::ROW_W-1:0]   cursor_row_o,
  output logic                         scrolled_o,
  output logic [tcce_pkg::CELL_W-1:0]  read_cell_o
);
  import tcce_pkg::*;

  localparam int AW = $clog2(COLUMNS * ROWS);

  typedef struct packed {
    op_e                op;
    logic               scroll;
    logic [AW-1:0]      addr;
    logic [CHAR_W-1:0]  glyph;
    logic [ATTR_W-1:0]  attr;
    logic               read_ok;
    logic [INDEX_W-1:0] cur_index;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
  } entry_t;

  logic   init_done;
  logic   push_valid, push_ready;
  logic   pop_valid, pop_ready;
  entry_t push_data, pop_data;

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .entry_t (entry_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_done_i  (init_done),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tcce_queue #(
    .entry_t (entry_t)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .entry_t (entry_t)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .init_done_o    (init_done),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_index_o (cursor_index_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .scrolled_o     (scrolled_o),
    .read_cell_o    (read_cell_o)
  );

endmodule

[test/text_console_cursor_engine_tb.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Self-checking bench for the text console cursor engine. A scoreboard keeps
// its own copy of the screen, cursor and attribute, predicts the cursor report
// of every accepted request and compares it field by field with the block's
// output. Directed requests cover the control characters and read corners;
// random phases under different attributes mix text runs, line-feed bursts
// that drive scrolling, reads and clears, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int CELLS = DEF_COLUMNS * DEF_ROWS;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ATTR_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i;
  logic [CHAR_W-1:0]    char_code_i;
  logic [INDEX_W-1:0]   cell_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [INDEX_W-1:0]   cursor_index_o;
  logic [COL_W-1:0]     cursor_col_o;
  logic [ROW_W-1:0]     cursor_row_o;
  logic                 scrolled_o;
  logic [CELL_W-1:0]    read_cell_o;

  text_console_cursor_engine #(
    .COLUMNS(DEF_COLUMNS),
    .ROWS   (DEF_ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .cell_index_i  (cell_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cursor_index_o(cursor_index_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_row_o  (cursor_row_o),
    .scrolled_o    (scrolled_o),
    .read_cell_o   (read_cell_o)
  );

  typedef struct {
    logic [INDEX_W-1:0] cursor_index;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               scrolled;
    logic [CELL_W-1:0]  cell_value;
  } cursor_report_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       column;
    int unsigned       row;
    logic [ATTR_W-1:0] attribute;
    cursor_report_t    expected_reports[$];
    int                mismatches;
    int                checked;
    int                scroll_count;
    int                read_count;
    int                clear_count;

    function new();
      foreach (screen[i]) screen[i] = RESET_BLANK;
      column       = 0;
      row          = 0;
      attribute    = RESET_ATTR;
      mismatches   = 0;
      checked      = 0;
      scroll_count = 0;
      read_count   = 0;
      clear_count  = 0;
    endfunction

    function void fill_blank(int unsigned first, int unsigned count);
      for (int unsigned i = first; i < first + count; i++) screen[i] = {attribute, CH_SPACE};
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
      cursor_report_t r;
      int unsigned    lin;
      r.scrolled   = 1'b0;
      r.cell_value = '0;
      case (func)
        FUNC_PUT: begin
          if (ch == CH_BS) begin
            if (column != 0) column--;
          end else if (ch == CH_TAB) begin
            column = (column + TAB_STOP) & ~(TAB_STOP - 1);
          end else if (ch == CH_CR) begin
            column = 0;
          end else if (ch == CH_LF) begin
            column = 0;
            row++;
          end else if (ch >= CH_SPACE) begin
            screen[row * DEF_COLUMNS + column] = {attribute, ch};
            column++;
          end
          if (column >= DEF_COLUMNS) begin
            column = 0;
            row++;
          end
          // shift every line up and blank the new bottom line
          if (row >= DEF_ROWS) begin
            for (int i = 0; i < CELLS - DEF_COLUMNS; i++) screen[i] = screen[i + DEF_COLUMNS];
            fill_blank(CELLS - DEF_COLUMNS, DEF_COLUMNS);
            row = DEF_ROWS - 1;
            r.scrolled = 1'b1;
            scroll_count++;
          end
        end
        FUNC_CLEAR: begin
          fill_blank(0, CELLS);
          column = 0;
          row    = 0;
          clear_count++;
        end
        FUNC_READ: begin
          if (idx < CELLS) r.cell_value = screen[idx];
          read_count++;
        end
        default: ;
      endcase
      lin            = row * DEF_COLUMNS + column;
      r.cursor_index = INDEX_W'(lin);
      r.col          = COL_W'(column);
      r.row          = ROW_W'(row);
      expected_reports.push_back(r);
    endfunction

    function void check_report(logic [INDEX_W-1:0] got_index, logic [COL_W-1:0] got_col,
                               logic [ROW_W-1:0] got_row, logic got_scrolled,
                               logic [CELL_W-1:0] got_cell);
      cursor_report_t r;
      if (expected_reports.size() == 0) begin
        $error("result with no request pending: cursor_index %0d", got_index);
        mismatches++;
        return;
      end
      r = expected_reports.pop_front();
      checked++;
      if (got_index !== r.cursor_index) begin
        $error("cursor_index: expected %0d, got %0d", r.cursor_index, got_index);
        mismatches++;
      end
      if (got_col !== r.col) begin
        $error("cursor_col: expected %0d, got %0d", r.col, got_col);
        mismatches++;
      end
      if (got_row !== r.row) begin
        $error("cursor_row: expected %0d, got %0d", r.row, got_row);
        mismatches++;
      end
      if (got_scrolled !== r.scrolled) begin
        $error("scrolled: expected %0d, got %0d", r.scrolled, got_scrolled);
        mismatches++;
      end
      if (got_cell !== r.cell_value) begin
        $error("read_cell: expected 0x%04h, got 0x%04h", r.cell_value, got_cell);
        mismatches++;
      end
    endfunction
  endclass

  console_scoreboard sb;
  bit                steady_send;
  int                request_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #50_000_000;
    $display("[text_console_cursor_engine] ERROR");
    $finish;
  end

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(f, ch, idx);
    request_count++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_request(FUNC_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.attribute = value;
  endtask

  task automatic random_phase(input int quota);
    int                 counted;
    int                 kind;
    int                 len;
    int unsigned        lin;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 7) == 0) steady_send = !steady_send;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // text run, now and then long enough to wrap the line
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) put_char(CHAR_W'($urandom_range(32, 255)));
        counted += len;
      end else if (kind < 50) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        for (int i = 0; i < len; i++) put_char(CH_LF);
        counted += len;
      end else if (kind < 60) begin
        case ($urandom_range(0, 3))
          0: put_char(CH_BS);
          1: put_char(CH_TAB);
          2: put_char(CH_CR);
          default: put_char(CH_LF);
        endcase
        counted++;
      end else if (kind < 65) begin
        // no effect on the screen; not counted
        if ($urandom_range(0, 1) == 0) begin
          send_request(FUNC_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
        end else begin
          do ch = CHAR_W'($urandom_range(0, 31));
          while (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
          put_char(ch);
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          lin = sb.row * DEF_COLUMNS + sb.column;
          case ($urandom_range(0, 3))
            0: idx = INDEX_W'((lin > 0) ? lin - 1 : 0);
            1: idx = INDEX_W'($urandom_range(0, CELLS - 1));
            2: idx = INDEX_W'($urandom_range(CELLS - DEF_COLUMNS, CELLS - 1));
            default: idx = INDEX_W'($urandom_range(CELLS, 2047));
          endcase
          send_request(FUNC_READ, CHAR_W'($urandom), idx);
        end
        counted += len;
      end else if (kind < 92) begin
        send_request(FUNC_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
        counted++;
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) put_char(CH_BS);
        counted += len;
      end
    end
  endtask

  // result side: random back-pressure with occasional steady stretches
  initial begin
    int stall;
    bit steady;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_report(cursor_index_o, cursor_col_o, cursor_row_o, scrolled_o, read_cell_o);
    end
  end

  initial begin
    logic [ATTR_W-1:0] phase_attr [4];
    sb            = new();
    steady_send   = 1'b0;
    request_count = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_PUT;
    char_code_i   <= '0;
    cell_index_i  <= '0;
    out_ready_i   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset screen, ignored bytes, backspace at the left edge,
    // extreme characters, tab stops up to the wrap, read corners
    send_request(FUNC_READ, 8'h00, 11'd0);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(CH_BS);
    put_char(CH_SPACE);
    put_char(8'hFF);
    put_char(8'h41);
    put_char(CH_BS);
    for (int i = 0; i < 10; i++) put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_LF);
    send_request(FUNC_READ, 8'hFF, 11'd1);
    send_request(FUNC_READ, 8'h00, INDEX_W'(CELLS));
    send_request(FUNC_READ, 8'h00, 11'h7FF);
    send_request(FUNC_UNUSED, 8'hFF, 11'h7FF);
    send_request(FUNC_CLEAR, 8'h00, 11'd0);
    drain_requests();

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom_range(1, 254));
    phase_attr[3] = 8'h4E;
    for (int p = 0; p < 4; p++) begin
      write_attribute(phase_attr[p]);
      random_phase(100);
      drain_requests();
    end

    // hold for any stray result
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests (%0d reads, %0d clears) under 5 attribute settings.",
             request_count, sb.read_count, sb.clear_count);
    $display("Checked %0d cursor reports, %0d of them after a scroll; %0d mismatches.",
             sb.checked, sb.scroll_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[text_console_cursor_engine] OK");
    end else begin
      $display("[text_console_cursor_engine] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/tcce_pkg.sv
src/tcce_queue.sv
src/tcce_front.sv
src/tcce_back.sv
src/text_console_cursor_engine.sv
test/text_console_cursor_engine_tb.sv
